>>> src/oms_pkg.sv
// Shared types and constants of the one-shot modifier pair.
package oms_pkg;

	typedef struct packed {
		logic [1:0]  op;
		logic        pressed;
		logic [15:0] now_ms;
	} evt_t;

	typedef struct packed {
		logic [7:0] modifier_code;
		logic       action;
		logic       last;
	} res_t;

	localparam logic [1:0] OP_FIRST_KEY  = 2'd0;
	localparam logic [1:0] OP_SECOND_KEY = 2'd1;
	localparam logic [1:0] OP_LAYER_KEY  = 2'd2;
	localparam logic [1:0] OP_OTHER_KEY  = 2'd3;

	localparam logic [2:0] MODE_DISABLED           = 3'd0;
	localparam logic [2:0] MODE_TRIGGER            = 3'd1;
	localparam logic [2:0] MODE_HOLDING            = 3'd2;
	localparam logic [2:0] MODE_RELEASE_AFTER_HOLD = 3'd3;
	localparam logic [2:0] MODE_RELEASE            = 3'd4;

	localparam logic ACT_REGISTER   = 1'b0;
	localparam logic ACT_UNREGISTER = 1'b1;

	localparam logic [1:0] REG_TIMEOUT     = 2'd0;
	localparam logic [1:0] REG_FIRST_CODE  = 2'd1;
	localparam logic [1:0] REG_SECOND_CODE = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET     = 16'd1500;
	localparam logic [7:0]  FIRST_CODE_RESET  = 8'd225;
	localparam logic [7:0]  SECOND_CODE_RESET = 8'd224;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] start;
		logic        emit;
		logic        action;
	} step_t;

endpackage

>>> src/one_shot_modifier_pair.sv
// Top level: two one-shot modifier machines with an input register and result queue.
// Each event waits in the input register, then its results enter the result queue.
// Throughput: one event per cycle while events give at most one result and no result
// stall is held; otherwise the two-entry queue can fill and stall events.
// Reset: both machines disabled with no timer, registers at their reset values,
// input register and result queue empty.
module one_shot_modifier_pair (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  oms_pkg::evt_t        evt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output oms_pkg::res_t        res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import oms_pkg::*;

	logic [15:0] timeout_q;
	logic [7:0]  first_code_q;
	logic [7:0]  second_code_q;
	logic [2:0]  first_mode_q;
	logic [15:0] first_start_q;
	logic [2:0]  second_mode_q;
	logic [15:0] second_start_q;

	logic        valid_s1;
	evt_t        evt_s1;

	res_t        fifo_q [0:1];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	step_t       first_own;
	step_t       second_own;
	step_t       first_oth;
	step_t       second_oth;
	step_t       first_nxt;
	step_t       second_nxt;
	res_t        res0;
	res_t        res1;
	logic [1:0]  n_res;
	logic        pop;
	logic [2:0]  count_after;
	logic        fits;
	logic        adv;
	logic        take;

	function automatic step_t own_key(input logic [2:0] mode, input logic [15:0] start,
			input logic pressed, input logic [15:0] now);
		step_t s;
		s.mode   = mode;
		s.start  = start;
		s.emit   = 1'b0;
		s.action = ACT_REGISTER;
		if (!pressed) begin
			if (mode == MODE_HOLDING) begin
				s.mode = MODE_TRIGGER;
			end else if (mode == MODE_RELEASE_AFTER_HOLD) begin
				s.mode   = MODE_DISABLED;
				s.emit   = 1'b1;
				s.action = ACT_UNREGISTER;
			end
		end else if (mode != MODE_DISABLED) begin
			s.mode  = MODE_DISABLED;
			s.start = 16'd0;
		end else begin
			s.mode  = MODE_HOLDING;
			s.start = now;
		end
		return s;
	endfunction

	function automatic step_t other_key(input logic [2:0] mode, input logic [15:0] start,
			input logic [15:0] now, input logic [15:0] timeout);
		step_t       s;
		logic [15:0] elapsed;
		s.mode   = mode;
		s.start  = start;
		s.emit   = 1'b0;
		s.action = ACT_REGISTER;
		elapsed  = now - start;
		if (mode == MODE_HOLDING) begin
			s.start = 16'd0;
			s.mode  = MODE_RELEASE_AFTER_HOLD;
			s.emit  = 1'b1;
		end else if (mode == MODE_TRIGGER) begin
			if (start != 16'd0 && elapsed > timeout) begin
				s.start = 16'd0;
				s.mode  = MODE_DISABLED;
			end else begin
				s.mode = MODE_RELEASE;
				s.emit = 1'b1;
			end
		end else if (mode == MODE_RELEASE) begin
			s.mode   = MODE_DISABLED;
			s.emit   = 1'b1;
			s.action = ACT_UNREGISTER;
		end
		return s;
	endfunction

	always_comb begin
		first_own  = own_key(first_mode_q, first_start_q, evt_s1.pressed, evt_s1.now_ms);
		second_own = own_key(second_mode_q, second_start_q, evt_s1.pressed, evt_s1.now_ms);
		first_oth  = other_key(first_mode_q, first_start_q, evt_s1.now_ms, timeout_q);
		second_oth = other_key(second_mode_q, second_start_q, evt_s1.now_ms, timeout_q);
		first_nxt  = '{mode: first_mode_q, start: first_start_q, emit: 1'b0,
			action: ACT_REGISTER};
		second_nxt = '{mode: second_mode_q, start: second_start_q, emit: 1'b0,
			action: ACT_REGISTER};
		unique case (evt_s1.op)
			OP_FIRST_KEY:  first_nxt = first_own;
			OP_SECOND_KEY: second_nxt = second_own;
			OP_LAYER_KEY:  ;
			OP_OTHER_KEY: begin
				first_nxt  = first_oth;
				second_nxt = second_oth;
			end
			default: ;
		endcase
	end

	always_comb begin
		n_res = {1'b0, first_nxt.emit} + {1'b0, second_nxt.emit};
		res1  = '{modifier_code: second_code_q, action: second_nxt.action, last: 1'b1};
		if (first_nxt.emit) begin
			res0 = '{modifier_code: first_code_q, action: first_nxt.action,
				last: !second_nxt.emit};
		end else begin
			res0 = res1;
		end
	end

	assign pop         = res_valid && !res_stall;
	assign count_after = {1'b0, count_q} - {2'b0, pop} + {1'b0, n_res};
	assign fits        = count_after <= 3'd2;
	assign adv         = valid_s1 && fits;
	assign take        = evt_valid && !evt_stall;
	assign evt_stall   = valid_s1 && !fits;
	assign cfg_ready   = 1'b1;
	assign res_valid   = count_q != 2'd0;
	assign res         = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RESET;
			first_code_q  <= FIRST_CODE_RESET;
			second_code_q <= SECOND_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT:     timeout_q <= cfg_data;
				REG_FIRST_CODE:  first_code_q <= cfg_data[7:0];
				REG_SECOND_CODE: second_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_mode_q   <= MODE_DISABLED;
			first_start_q  <= 16'd0;
			second_mode_q  <= MODE_DISABLED;
			second_start_q <= 16'd0;
		end else if (adv) begin
			first_mode_q   <= first_nxt.mode;
			first_start_q  <= first_nxt.start;
			second_mode_q  <= second_nxt.mode;
			second_start_q <= second_nxt.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1 <= evt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				fifo_q[!wr_ptr_q] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q ^ n_res[0];
				count_q  <= count_after[1:0];
			end else begin
				count_q  <= count_q - {1'b0, pop};
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

endmodule

>>> test/one_shot_modifier_pair_tb.sv
// Self-checking testbench for the one-shot modifier pair, with its own model of both machines.
`timescale 1ns / 100ps

module one_shot_modifier_pair_tb;
	import oms_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt_item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_TIMEOUT;
	logic [15:0] cfg_data = '0;

	logic [2:0] mode_q [2];
	logic [15:0] start_q [2];
	logic [7:0] code_cfg [2];
	logic [15:0] timeout_cfg;
	res_t pending_res [$];
	res_t want_res;

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned phase_items = 0;
	bit idle_on = 1'b1;
	logic [15:0] clock_ms = '0;

	one_shot_modifier_pair uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit own_key_step(int m, logic pressed, logic [15:0] now,
			output logic act);
		bit hit;
		hit = 1'b0;
		act = ACT_REGISTER;
		if (!pressed) begin
			if (mode_q[m] == MODE_HOLDING) begin
				mode_q[m] = MODE_TRIGGER;
			end else if (mode_q[m] == MODE_RELEASE_AFTER_HOLD) begin
				mode_q[m] = MODE_DISABLED;
				act = ACT_UNREGISTER;
				hit = 1'b1;
			end
		end else if (mode_q[m] != MODE_DISABLED) begin
			mode_q[m] = MODE_DISABLED;
			start_q[m] = '0;
		end else begin
			mode_q[m] = MODE_HOLDING;
			start_q[m] = now;
		end
		return hit;
	endfunction

	function automatic bit other_key_step(int m, logic [15:0] now, output logic act);
		bit hit;
		logic [15:0] elapsed;
		hit = 1'b0;
		act = ACT_REGISTER;
		case (mode_q[m])
			MODE_HOLDING: begin
				start_q[m] = '0;
				mode_q[m] = MODE_RELEASE_AFTER_HOLD;
				hit = 1'b1;
			end
			MODE_TRIGGER: begin
				elapsed = now - start_q[m];
				if (start_q[m] != '0 && elapsed > timeout_cfg) begin
					start_q[m] = '0;
					mode_q[m] = MODE_DISABLED;
				end else begin
					mode_q[m] = MODE_RELEASE;
					hit = 1'b1;
				end
			end
			MODE_RELEASE: begin
				mode_q[m] = MODE_DISABLED;
				act = ACT_UNREGISTER;
				hit = 1'b1;
			end
			default: ;
		endcase
		return hit;
	endfunction

	task automatic predict_modifiers(input evt_t e);
		res_t outs [$];
		res_t r;
		logic act;
		int m;
		r = '0;
		if (e.op == OP_FIRST_KEY || e.op == OP_SECOND_KEY) begin
			m = (e.op == OP_SECOND_KEY) ? 1 : 0;
			if (own_key_step(m, e.pressed, e.now_ms, act)) begin
				r.modifier_code = code_cfg[m];
				r.action = act;
				outs.push_back(r);
			end
		end else if (e.op == OP_OTHER_KEY) begin
			for (m = 0; m < 2; m++) begin
				if (other_key_step(m, e.now_ms, act)) begin
					r.modifier_code = code_cfg[m];
					r.action = act;
					outs.push_back(r);
				end
			end
		end
		if (outs.size() != 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			pending_res.push_back(outs[i]);
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				report_mismatch($sformatf("unexpected result code %0d action %0b last %0b",
					res_item.modifier_code, res_item.action, res_item.last));
			end else begin
				want_res = pending_res.pop_front();
				if (res_item.modifier_code !== want_res.modifier_code)
					report_mismatch($sformatf("modifier_code %0d, expected %0d",
						res_item.modifier_code, want_res.modifier_code));
				if (res_item.action !== want_res.action)
					report_mismatch($sformatf("action %0b, expected %0b",
						res_item.action, want_res.action));
				if (res_item.last !== want_res.last)
					report_mismatch($sformatf("last %0b, expected %0b",
						res_item.last, want_res.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		res_stall <= (stall_left != 0);
	end

	task automatic send_event(input evt_t e);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			evt_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		evt_item <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall);
		predict_modifiers(e);
		if (e.op != OP_LAYER_KEY)
			phase_items++;
	endtask

	task automatic send_key(input logic [1:0] op, input logic pressed,
			input int unsigned delay_ms);
		evt_t e;
		clock_ms = clock_ms + delay_ms[15:0];
		e.op = op;
		e.pressed = pressed;
		e.now_ms = clock_ms;
		send_event(e);
	endtask

	task automatic send_noise();
		evt_t e;
		e.op = 2'($urandom_range(0, 3));
		e.pressed = 1'($urandom_range(0, 1));
		e.now_ms = 16'($urandom_range(0, 65535));
		send_event(e);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_TIMEOUT: timeout_cfg = data;
			REG_FIRST_CODE: code_cfg[0] = data[7:0];
			REG_SECOND_CODE: code_cfg[1] = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [15:0] timeout, input logic [7:0] first_code,
			input logic [7:0] second_code);
		wait_idle();
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_FIRST_CODE, {8'h00, first_code});
		write_reg(REG_SECOND_CODE, {8'h00, second_code});
	endtask

	function automatic int unsigned pick_delay_ms();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 20);
			1: return timeout_cfg + $urandom_range(0, 2) - 1;
			2: return $urandom_range(0, timeout_cfg);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic run_traffic(input int unsigned n_items);
		logic [1:0] own;
		int reps;
		phase_items = 0;
		clock_ms = 16'($urandom_range(0, 65535));
		while (phase_items < n_items) begin
			own = $urandom_range(0, 1) ? OP_SECOND_KEY : OP_FIRST_KEY;
			case ($urandom_range(0, 7))
				0, 1: begin
					send_key(own, 1'b1, $urandom_range(1, 200));
					send_key(own, 1'b0, $urandom_range(0, 200));
					reps = $urandom_range(1, 2);
					send_key(OP_OTHER_KEY, 1'($urandom_range(0, 1)), pick_delay_ms());
					if (reps == 2)
						send_key(OP_OTHER_KEY, 1'($urandom_range(0, 1)),
							$urandom_range(0, 50));
				end
				2, 3: begin
					send_key(own, 1'b1, $urandom_range(1, 200));
					reps = $urandom_range(1, 3);
					repeat (reps)
						send_key(OP_OTHER_KEY, 1'($urandom_range(0, 1)), pick_delay_ms());
					send_key(own, 1'b0, $urandom_range(0, 200));
				end
				4: begin
					send_key(OP_FIRST_KEY, 1'b1, $urandom_range(1, 100));
					send_key(OP_FIRST_KEY, 1'b0, $urandom_range(0, 100));
					send_key(OP_SECOND_KEY, 1'b1, $urandom_range(0, 100));
					send_key(OP_SECOND_KEY, 1'b0, $urandom_range(0, 100));
					send_key(OP_OTHER_KEY, 1'b1, pick_delay_ms());
					send_key(OP_OTHER_KEY, 1'b0, $urandom_range(0, 50));
				end
				5: begin
					send_key(own, 1'b1, $urandom_range(1, 200));
					if ($urandom_range(0, 1)) begin
						send_key(own, 1'b0, $urandom_range(0, 100));
						send_key(OP_OTHER_KEY, 1'b1, pick_delay_ms());
					end
					send_key(own, 1'b1, $urandom_range(0, 100));
				end
				6: begin
					reps = $urandom_range(1, 3);
					repeat (reps) send_noise();
				end
				default: begin
					send_key(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						pick_delay_ms());
				end
			endcase
		end
	endtask

	task automatic test_hold_across_key();
		clock_ms = 16'd100;
		send_key(OP_FIRST_KEY, 1'b1, 0);
		send_key(OP_OTHER_KEY, 1'b1, 10);
		send_key(OP_OTHER_KEY, 1'b0, 10);
		send_key(OP_FIRST_KEY, 1'b0, 10);
	endtask

	task automatic test_one_shot_tap();
		clock_ms = 16'd200;
		send_key(OP_SECOND_KEY, 1'b1, 0);
		send_key(OP_SECOND_KEY, 1'b0, 10);
		send_key(OP_FIRST_KEY, 1'b1, 10);
		send_key(OP_FIRST_KEY, 1'b0, 10);
		send_key(OP_OTHER_KEY, 1'b1, 10);
		send_key(OP_OTHER_KEY, 1'b0, 10);
		send_key(OP_FIRST_KEY, 1'b0, 10);
	endtask

	task automatic test_timeout_expiry();
		clock_ms = 16'd1000;
		send_key(OP_FIRST_KEY, 1'b1, 0);
		send_key(OP_FIRST_KEY, 1'b0, 0);
		send_key(OP_OTHER_KEY, 1'b1, 1501);
		clock_ms = 16'hFFFF;
		send_key(OP_SECOND_KEY, 1'b1, 0);
		send_key(OP_SECOND_KEY, 1'b0, 0);
		send_key(OP_OTHER_KEY, 1'b1, 1500);
		send_key(OP_OTHER_KEY, 1'b0, 1);
		clock_ms = 16'd0;
		send_key(OP_FIRST_KEY, 1'b1, 0);
		send_key(OP_FIRST_KEY, 1'b0, 5);
		send_key(OP_OTHER_KEY, 1'b1, 40000);
	endtask

	task automatic test_cancel_and_ignored_keys();
		clock_ms = 16'd300;
		send_key(OP_FIRST_KEY, 1'b1, 0);
		send_key(OP_FIRST_KEY, 1'b1, 10);
		send_key(OP_SECOND_KEY, 1'b1, 10);
		send_key(OP_SECOND_KEY, 1'b0, 10);
		send_key(OP_OTHER_KEY, 1'b1, 10);
		send_key(OP_SECOND_KEY, 1'b1, 10);
		send_key(OP_LAYER_KEY, 1'b1, 10);
		send_key(OP_LAYER_KEY, 1'b0, 10);
	endtask

	task automatic test_register_extremes();
		set_registers(16'd0, 8'd0, 8'd255);
		run_traffic(120);
		set_registers(16'hFFFF, 8'd255, 8'd0);
		run_traffic(120);
	endtask

	task automatic test_mid_stream_pause();
		set_registers(16'($urandom_range(1, 3000)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		run_traffic(100);
		wait_idle();
		run_traffic(100);
	endtask

	task automatic test_back_to_back();
		set_registers(TIMEOUT_RESET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		idle_on = 1'b0;
		run_traffic(200);
	endtask

	initial begin
		timeout_cfg = TIMEOUT_RESET;
		code_cfg[0] = FIRST_CODE_RESET;
		code_cfg[1] = SECOND_CODE_RESET;
		mode_q[0] = MODE_DISABLED;
		mode_q[1] = MODE_DISABLED;
		start_q[0] = '0;
		start_q[1] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_hold_across_key();
		test_one_shot_tap();
		test_timeout_expiry();
		test_cancel_and_ignored_keys();
		run_traffic(200);
		test_register_extremes();
		test_mid_stream_pause();
		test_back_to_back();

		wait_idle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
